// File: rtl/rmsn_pkg.sv
// rmsn_pkg: shared types and constants of the rms row normalizer
// holds the sequencer state type, register indexes and fixed-point constants
// no dependencies
package rmsn_pkg;

    localparam int ROW_MAX_DEFAULT     = 64;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    localparam int ROW_LEN_W = 7;
    localparam int EPS_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;

    localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 7'd64;
    localparam logic [EPS_W-1:0]     EPS_RESET     = 24'd168;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 2'd1;

    // fixed-point layout: inverse root is Q.16, outputs Q.12
    localparam int FRAC_BITS  = 12;
    localparam int INV_FRAC   = 16;
    localparam int INV_W      = 29;
    localparam int INV_NUM_SH = 56;
    localparam int INV_NUM_W  = INV_NUM_SH + 1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIV_MEAN,
        ST_DIV_INV,
        ST_SQRT,
        ST_EMIT_RD,
        ST_EMIT_MUL1,
        ST_EMIT_MUL2,
        ST_EMIT_OUT
    } rmsn_state_t;

endpackage

// File: rtl/rms_row_normalizer.sv
// rms_row_normalizer: top level, stores a row, finds its inverse rms and emits scaled outputs
// depends on rmsn_pkg for the state type, register indexes and constants
//
//  channel   signals                                        direction
//  -------   --------------------------------------------   ---------
//  input     in_valid, in_ready, sample_in, scale_in         in
//  output    out_valid, out_ready, norm_out, out_last,       out
//            out_saturated
//  config    cfg_we, cfg_index, cfg_data                     in
//
//  input is accepted whenever in_valid is high while a row fills
//  after the last element of a row the shared subtract unit runs the mean division
//  (DV_W steps), the 2^56/v division (DV_W steps) and the integer root (DV_W/2 steps),
//  skipping the last two when the mean square plus epsilon is zero, input held not ready
//  each output element then passes four states: memory read, two multiplies, output load
//  reset clears the sequencer, counters and the square sum, and sets the config defaults
//  the output register lets the next row start loading while the last result waits
module rms_row_normalizer
#(
    parameter int ROW_MAX     = rmsn_pkg::ROW_MAX_DEFAULT,
    parameter int SAMPLE_BITS = rmsn_pkg::SAMPLE_BITS_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rmsn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rmsn_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SAMPLE_BITS-1:0]        sample_in,
    input  logic signed [SAMPLE_BITS-1:0]        scale_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [SAMPLE_BITS-1:0]        norm_out,
    output logic                                 out_last,
    output logic                                 out_saturated
);
    import rmsn_pkg::*;

    localparam int SB      = SAMPLE_BITS;
    localparam int CNT_W   = $clog2(ROW_MAX + 1);
    localparam int AW      = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
    localparam int SUM_W   = 2 * SB + CNT_W;
    localparam int V_W     = ((SUM_W > EPS_W) ? SUM_W : EPS_W) + 1;
    localparam int DV_RAW  = (SUM_W > INV_NUM_W) ? SUM_W : INV_NUM_W;
    localparam int DV_W    = DV_RAW + (DV_RAW % 2);
    localparam int ROOT_W  = DV_W / 2;
    localparam int W       = ((V_W + 1) > (ROOT_W + 3)) ? (V_W + 1) : (ROOT_W + 3);
    localparam int ITER_W  = $clog2(DV_W + 1);
    localparam int P1_W    = SB + INV_W + 1;
    localparam int NV_W    = P1_W - INV_FRAC + 1;
    localparam int P2_W    = NV_W + SB;

    // config registers
    logic [ROW_LEN_W-1:0] row_length_reg;
    logic [EPS_W-1:0]     eps_reg;

    // sequencer and datapath registers
    rmsn_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [W-1:0]         rem_reg, rem_next;
    logic [DV_W-1:0]      dvd_reg, dvd_next;
    logic [V_W-1:0]       div_reg, div_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic [INV_W-1:0]     inv_reg, inv_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;
    logic signed [P1_W-1:0] p1_reg, p1_next;
    logic signed [P2_W-1:0] p2_reg, p2_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [SB-1:0]        norm_reg, norm_next;
    logic                 last_reg, last_next;
    logic                 sat_reg, sat_next;

    // row store: sample in the upper half, scale in the lower
    logic [2*SB-1:0]      row_mem [ROW_MAX];
    logic [2*SB-1:0]      rd_reg;
    logic                 mem_we;

    // shared subtract unit
    logic [W-1:0]         alu_a, alu_b;
    logic [W:0]           alu_diff;
    logic                 alu_ge;

    logic [ROW_LEN_W-1:0] len_eff;
    logic                 in_fire;
    logic [SB-1:0]        in_mag;
    logic [2*SB-1:0]      in_sq;
    logic [CNT_W-1:0]     fill_inc;
    logic [DV_W-1:0]      q_shift;
    logic [ROOT_W-1:0]    root_shift;
    logic [V_W-1:0]       v_val;
    logic signed [SB-1:0] rd_sample, rd_scale;
    logic [P1_W-1:0]      p1_mag, p1_rnd;
    logic [P1_W-1:0]      nv_full;
    logic signed [NV_W-1:0] nv_val;
    logic [P2_W-1:0]      p2_mag, p2_rnd;
    logic [P2_W-1:0]      y_val;
    logic                 sat_hi, sat_lo;

    // effective row length: zero acts as one, large values clip to the store depth
    always_comb
    begin
        if (row_length_reg == '0)
            len_eff = ROW_LEN_W'(1);
        else if (row_length_reg > ROW_LEN_W'(ROW_MAX))
            len_eff = ROW_LEN_W'(ROW_MAX);
        else
            len_eff = row_length_reg;
    end

    assign in_ready = (state_reg == ST_LOAD);
    assign in_fire  = in_valid && in_ready;
    assign in_mag   = sample_in[SB-1] ? SB'(-sample_in) : SB'(sample_in);
    assign in_sq    = {{SB{1'b0}}, in_mag} * {{SB{1'b0}}, in_mag};
    assign fill_inc = fill_reg + CNT_W'(1);
    assign mem_we   = in_fire;

    // operand select of the shared unit: one division step or one root step
    always_comb
    begin
        if (state_reg == ST_SQRT)
        begin
            alu_a = {rem_reg[W-3:0], dvd_reg[DV_W-1 -: 2]};
            alu_b = {{(W-ROOT_W-2){1'b0}}, root_reg, 2'b01};
        end
        else
        begin
            alu_a = {rem_reg[W-2:0], dvd_reg[DV_W-1]};
            alu_b = {{(W-V_W){1'b0}}, div_reg};
        end
        alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
        alu_ge   = !alu_diff[W];
    end

    assign q_shift    = {dvd_reg[DV_W-2:0], alu_ge};
    assign root_shift = {root_reg[ROOT_W-2:0], alu_ge};
    assign v_val      = V_W'(q_shift[SUM_W-1:0]) + V_W'(eps_reg);

    // emit datapath: round(sample*inv/2^16), then round(nv*scale/2^12), then clip
    assign rd_sample = rd_reg[2*SB-1:SB];
    assign rd_scale  = rd_reg[SB-1:0];

    always_comb
    begin
        p1_next = rd_sample * $signed({1'b0, inv_reg});
        p1_mag  = p1_reg[P1_W-1] ? P1_W'(-p1_reg) : P1_W'(p1_reg);
        p1_rnd  = (p1_mag + P1_W'(1 << (INV_FRAC - 1))) >> INV_FRAC;
        nv_full = p1_reg[P1_W-1] ? P1_W'(-p1_rnd) : p1_rnd;
        nv_val  = nv_full[NV_W-1:0];
        p2_next = nv_val * rd_scale;
        p2_mag  = p2_reg[P2_W-1] ? P2_W'(-p2_reg) : P2_W'(p2_reg);
        p2_rnd  = (p2_mag + P2_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        y_val   = p2_reg[P2_W-1] ? P2_W'(-p2_rnd) : p2_rnd;
        sat_hi  = !y_val[P2_W-1] && (y_val[P2_W-2:SB-1] != '0);
        sat_lo  = y_val[P2_W-1] && (y_val[P2_W-2:SB-1] != '1);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        div_next       = div_reg;
        root_next      = root_reg;
        inv_next       = inv_reg;
        iter_next      = iter_reg;
        norm_next      = norm_reg;
        last_next      = last_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if ({1'b0, fill_inc} >= (CNT_W+1)'(len_eff))
                    begin
                        // row complete: start the mean division
                        n_next     = fill_inc;
                        dvd_next   = DV_W'(sum_reg + SUM_W'(in_sq));
                        div_next   = V_W'(fill_inc);
                        rem_next   = '0;
                        iter_next  = '0;
                        sum_next   = '0;
                        fill_next  = '0;
                        state_next = ST_DIV_MEAN;
                    end
                    else
                    begin
                        sum_next  = sum_reg + SUM_W'(in_sq);
                        fill_next = fill_inc;
                    end
                end
            end
            ST_DIV_MEAN:
            begin
                rem_next  = alu_ge ? alu_diff[W-1:0] : alu_a;
                dvd_next  = q_shift;
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(DV_W - 1))
                begin
                    rem_next  = '0;
                    iter_next = '0;
                    if (v_val == '0)
                    begin
                        // zero variance: saturated inverse root
                        inv_next   = '1;
                        idx_next   = '0;
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        div_next   = v_val;
                        dvd_next   = DV_W'(1) << INV_NUM_SH;
                        state_next = ST_DIV_INV;
                    end
                end
            end
            ST_DIV_INV:
            begin
                rem_next  = alu_ge ? alu_diff[W-1:0] : alu_a;
                dvd_next  = q_shift;
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(DV_W - 1))
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    iter_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                rem_next  = alu_ge ? alu_diff[W-1:0] : alu_a;
                root_next = root_shift;
                dvd_next  = {dvd_reg[DV_W-3:0], 2'b00};
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(ROOT_W - 1))
                begin
                    inv_next   = root_shift[INV_W-1:0];
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_MUL1;
            end
            ST_EMIT_MUL1:
            begin
                state_next = ST_EMIT_MUL2;
            end
            ST_EMIT_MUL2:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    sat_next       = sat_hi || sat_lo;
                    if (sat_hi)
                        norm_next = {1'b0, {(SB-1){1'b1}}};
                    else if (sat_lo)
                        norm_next = {1'b1, {(SB-1){1'b0}}};
                    else
                        norm_next = y_val[SB-1:0];
                    last_next = (idx_reg == n_reg - CNT_W'(1));
                    idx_next  = idx_reg + CNT_W'(1);
                    if (idx_reg == n_reg - CNT_W'(1))
                        state_next = ST_LOAD;
                    else
                        state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            fill_reg       <= '0;
            sum_reg        <= '0;
            iter_reg       <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            out_valid_reg  <= 1'b0;
            row_length_reg <= ROW_LEN_RESET;
            eps_reg        <= EPS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            iter_reg      <= iter_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ROW_LENGTH: row_length_reg <= cfg_data[ROW_LEN_W-1:0];
                    CFG_EPSILON:    eps_reg        <= cfg_data[EPS_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        div_reg  <= div_next;
        root_reg <= root_next;
        inv_reg  <= inv_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        norm_reg <= norm_next;
        last_reg <= last_next;
        sat_reg  <= sat_next;
    end

    // row store, registered read at the emit index
    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_mem[fill_reg[AW-1:0]] <= {sample_in, scale_in};
        rd_reg <= row_mem[idx_reg[AW-1:0]];
    end

    assign out_valid     = out_valid_reg;
    assign norm_out      = norm_reg;
    assign out_last      = last_reg;
    assign out_saturated = sat_reg;

    // the fill counter never reaches the store depth while loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (fill_reg < CNT_W'(ROW_MAX)))
        else $error("fill count reached the store depth");

    // a transaction that completes the row starts the mean division
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && ({1'b0, fill_inc} >= (CNT_W+1)'(len_eff))) |=>
        (state_reg == ST_DIV_MEAN))
        else $error("row end did not start the division");

    // the root step leads only to itself or to the emit phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT) |=>
        ((state_reg == ST_SQRT) || (state_reg == ST_EMIT_RD)))
        else $error("bad exit from the root step");

    // the output register is loaded only when it is free or being drained
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(norm_reg)))
        else $error("pending result overwritten");

endmodule

// File: tb/sv/testbench.sv
// testbench: self-checking bench for rms_row_normalizer
// drives rows and register writes, predicts every output, checks them in order
// depends on rmsn_pkg and the rms_row_normalizer rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rmsn_pkg::*;

    localparam int ROWS_MAX = 64;
    localparam int LIMIT = 400000;
    // index past the register map, the write must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LOW = 2'd2;
    // settle wait after the last output, by then the block is back at loading
    localparam int SETTLE = 20;

    typedef struct packed {
        logic signed [15:0] norm;
        logic               last;
        logic               sat;
    } norm_result_t;

    typedef enum logic { ROW_WRITE, ROW_ITEM } step_kind_t;

    typedef struct {
        step_kind_t          kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]    data;
        logic signed [15:0]  sample;
        logic signed [15:0]  scale;
        bit                  known;   // typed-in expectation present
        norm_result_t        want;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] sample_in = '0;
    logic signed [15:0] scale_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] norm_out;
    logic out_last;
    logic out_saturated;

    rms_row_normalizer dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the block state and registers
    logic [6:0]          row_len_reg;
    logic [23:0]         eps_reg;
    logic signed [15:0]  held_sample [ROWS_MAX];
    logic signed [15:0]  held_scale [ROWS_MAX];
    longint unsigned     sq_acc;
    int                  filled;
    norm_result_t        pending_norms [$];
    norm_result_t        newest_norm;

    int  errors = 0;
    int  mismatches = 0;
    int  cycles = 0;
    int  accepted = 0;
    bit  quiet = 1'b0;   // no idling on either side

    // floor(2^56 / v) then integer root, all ones for zero variance
    function automatic longint unsigned inv_root(longint unsigned v);
        longint unsigned q;
        longint unsigned r;
        longint unsigned t;
        if (v == 0)
            return (64'd1 << 29) - 1;
        q = (64'd1 << 56) / v;
        r = 0;
        for (int b = 28; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= q)
                r = t;
        end
        return r;
    endfunction

    // round to nearest, ties away from zero
    function automatic longint rnd_shift(longint p, int sh);
        longint unsigned m;
        longint unsigned r;
        m = (p < 0) ? -p : p;
        r = (m + (64'd1 << (sh - 1))) >> sh;
        return (p < 0) ? -longint'(r) : longint'(r);
    endfunction

    task automatic absorb_element(logic signed [15:0] x, logic signed [15:0] s);
        int eff;
        longint unsigned inv;
        longint nv;
        longint y;
        norm_result_t r;
        eff = (row_len_reg < 1) ? 1 : (row_len_reg > ROWS_MAX) ? ROWS_MAX : row_len_reg;
        held_sample[filled % ROWS_MAX] = x;
        held_scale[filled % ROWS_MAX] = s;
        sq_acc += longint'(x) * longint'(x);
        filled++;
        if (filled < eff)
            return;
        inv = inv_root(sq_acc / filled + eps_reg);
        for (int i = 0; i < filled; i++)
        begin
            nv = rnd_shift(longint'(held_sample[i]) * longint'(inv), INV_FRAC);
            y = rnd_shift(nv * longint'(held_scale[i]), FRAC_BITS);
            r.sat = 1'b0;
            if (y > 32767)
            begin
                y = 32767;
                r.sat = 1'b1;
            end
            if (y < -32768)
            begin
                y = -32768;
                r.sat = 1'b1;
            end
            r.norm = y[15:0];
            r.last = (i + 1 == filled);
            pending_norms.push_back(r);
            newest_norm = r;
        end
        sq_acc = 0;
        filled = 0;
    endtask

    task automatic note_error(string what, norm_result_t want, norm_result_t got);
        errors++;
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected norm %0d last %0d sat %0d, got norm %0d last %0d sat %0d",
                     what, want.norm, want.last, want.sat, got.norm, got.last, got.sat);
    endtask

    // monitor: sample everything at the rising edge
    always @(posedge clk)
    begin
        norm_result_t got;
        norm_result_t want;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROW_LENGTH)
                    row_len_reg = cfg_data[6:0];
                else if (cfg_index == CFG_EPSILON)
                    eps_reg = cfg_data[23:0];
            end
            if (in_valid && in_ready)
            begin
                absorb_element(sample_in, scale_in);
                accepted++;
            end
            if (out_valid && out_ready)
            begin
                got = '{norm_out, out_last, out_saturated};
                if (pending_norms.size() == 0)
                begin
                    want = '0;
                    note_error("unexpected output transaction", want, got);
                end
                else
                begin
                    want = pending_norms.pop_front();
                    if (got !== want)
                        note_error("output transaction", want, got);
                end
            end
        end
    end

    // receiver side stalls
    always @(negedge clk)
        out_ready = quiet ? 1'b1 : ($urandom_range(99) >= 16);

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // wait for every predicted output, then let the block settle
    task automatic drain();
        while (pending_norms.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // one input transaction, caller is at a falling edge
    task automatic send_element(logic signed [15:0] x, logic signed [15:0] s);
        int seen;
        if (!quiet)
            while ($urandom_range(99) < 16)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        in_valid = 1'b1;
        sample_in = x;
        scale_in = s;
        seen = accepted;
        do
            @(negedge clk);
        while (accepted == seen);
        in_valid = 1'b0;
    endtask

    // random sample shapes: full range, small, zero, extremes
    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(9))
            0: return 16'sd0;
            1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            2, 3: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    step_t plan [$];

    task automatic add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        step_t st;
        st = '{ROW_WRITE, idx, val, 16'sd0, 16'sd0, 1'b0, '0};
        plan.push_back(st);
    endtask

    task automatic add_item(logic signed [15:0] x, logic signed [15:0] s,
                            bit known = 1'b0, norm_result_t want = '0);
        step_t st;
        st = '{ROW_ITEM, '0, '0, x, s, known, want};
        plan.push_back(st);
    endtask

    initial
    begin
        int lens [6];
        int eps_pick;
        row_len_reg = ROW_LEN_RESET;
        eps_reg = EPS_RESET;
        sq_acc = 0;
        filled = 0;

        // directed table
        add_write(CFG_ROW_LENGTH, 24'd1);
        add_write(CFG_EPSILON, 24'd0);
        // zero variance gives zero output
        add_item(16'sd0, 16'sh7fff, 1'b1, '{16'sd0, 1'b1, 1'b0});
        // most negative times most negative clips high
        add_item(16'sh8000, 16'sh8000, 1'b1, '{16'sh7fff, 1'b1, 1'b1});
        add_item(16'sh7fff, 16'sh7fff);
        add_item(16'sh7fff, 16'sh8000);
        add_item(16'sh8000, 16'sh7fff);
        add_item(16'sd1, 16'sd4096);
        // ignored writes to unmapped indexes
        add_write(CFG_UNMAPPED, 24'd5);
        add_write(CFG_UNMAPPED_LOW, 24'hffffff);
        add_write(CFG_EPSILON, 24'hffffff);
        add_item(16'sd0, 16'sd4096, 1'b1, '{16'sd0, 1'b1, 1'b0});
        add_item(16'sh8000, 16'sh8000);
        // length zero acts as one
        add_write(CFG_ROW_LENGTH, 24'd0);
        add_item(16'sd4096, 16'sd4096);
        // a length above the row limit is written, but no row is sent at it
        add_write(CFG_ROW_LENGTH, 24'd100);
        add_write(CFG_EPSILON, 24'd168);
        // length shortened mid-row
        add_write(CFG_ROW_LENGTH, 24'd5);
        add_item(16'sd100, 16'sh7fff);
        add_item(-16'sd100, 16'sh8000);
        add_item(16'sd3000, 16'sd4096);
        add_write(CFG_ROW_LENGTH, 24'd2);
        add_item(16'sd7, -16'sd4096);

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_WRITE)
            begin
                drain();
                write_reg(plan[k].idx, plan[k].data);
            end
            else
            begin
                send_element(plan[k].sample, plan[k].scale);
                if (plan[k].known)
                begin
                    @(negedge clk);
                    if (newest_norm !== plan[k].want)
                        note_error("typed expectation", plan[k].want, newest_norm);
                end
            end
        end

        // random phases, each runs whole rows at one setting
        lens = '{48, 1, 7, 16, 3, 12};
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            eps_pick = (ph == 0) ? 24'hffffff : (ph == 1) ? 0 : (ph == 2) ? 168 : $urandom_range(24'hffffff);
            write_reg(CFG_ROW_LENGTH, 24'(lens[ph]));
            write_reg(CFG_EPSILON, 24'(eps_pick));
            quiet = (ph == 3);   // long stretch with no idling
            for (int rr = 0; rr < ((lens[ph] >= 12) ? 1 : 12 / lens[ph]); rr++)
            begin
                // sender holds off until the previous row is out
                if (ph == 4 && rr == 2)
                    drain();
                for (int e = 0; e < lens[ph]; e++)
                    send_element(pick_value(), pick_value());
            end
            quiet = 1'b0;
        end

        drain();
        repeat (50) @(negedge clk);
        if (pending_norms.size() != 0)
            errors++;
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: sim.f
rtl/rmsn_pkg.sv
rtl/rms_row_normalizer.sv
tb/sv/testbench.sv
